/* hw/rtl/stc_pkg.sv */
package stc_pkg;

    localparam int ALU_W = 18;

    typedef logic [ALU_W-1:0] t_word;

    localparam t_word SEC_PER_DAY = 18'd86400;
    // starting divisors for the shifted-divisor steps
    localparam t_word HOUR_DIV0   = 18'd57600;   // 3600 << 4
    localparam t_word MIN_DIV0    = 18'd1920;    // 60 << 5
    localparam t_word WEEK_DIV0   = 18'd57344;   // 7 << 13
    localparam t_word QUAD_DAYS   = 18'd1461;    // one leap year plus three common years
    localparam t_word LEAP_DAYS   = 18'd366;
    localparam t_word COMMON_DAYS = 18'd365;

    localparam logic [11:0] YEAR_BASE    = 12'd2000;
    localparam logic [11:0] YEAR_DAYZERO = 12'd1999;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  DAY_LAST_DEC = 5'd31;
    localparam logic [3:0]  DOW_OFFSET   = 4'd5;
    localparam logic [3:0]  DAYS_IN_WEEK = 4'd7;

    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // days from Jan 1 through the end of month m; zero for m == 0
    function automatic logic [8:0] days_through(input logic [3:0] m, input logic leap);
        logic [8:0] v;
        v = '0;
        if (m != 4'd0 && m <= MONTH_DEC) begin
            v = CUM_DAYS[m - 4'd1];
            if (leap && m > 4'd1) begin
                v = v + 9'd1;
            end
        end
        return v;
    endfunction

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DAYS  = 9'b000000010,
        S_HOUR  = 9'b000000100,
        S_MIN   = 9'b000001000,
        S_DOW   = 9'b000010000,
        S_YEAR4 = 9'b000100000,
        S_YEAR  = 9'b001000000,
        S_MONTH = 9'b010000000,
        S_DAY   = 9'b100000000
    } t_state;

endpackage

/* hw/rtl/stc_subcmp.sv */
module stc_subcmp (
    input  stc_pkg::t_word i_a,
    input  stc_pkg::t_word i_b,
    output stc_pkg::t_word o_diff,
    output logic           o_ge,
    output logic           o_gt
);
    import stc_pkg::*;

    logic [ALU_W:0] w_full;

    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[ALU_W-1:0];
    assign o_ge   = ~w_full[ALU_W];
    assign o_gt   = ~w_full[ALU_W] && (w_full[ALU_W-1:0] != '0);

endmodule

/* hw/rtl/seconds_to_calendar.sv */
// Time from request accept to result valid is set by the four-year blocks, single years
// and months walked. One request at a time: a new request is taken only once the last has
// gone to the output register; a single 18-bit subtract/compare unit does every step.
// o_stall is high from accept until the result is moved to the output register, so a
// stalled output register holds off the next request.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_valid.
module seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_day_of_week
);
    import stc_pkg::*;

    // Sequence per request:
    //   S_DAYS  32 restoring steps: seconds / 86400, remainder is time of day
    //   S_HOUR  5 shifted-divisor steps: time / 3600
    //   S_MIN   6 steps: leftover / 60, last remainder is the second
    //   S_DOW   14 steps: day count mod 7
    //   S_YEAR4 peel four-year blocks of 1461 days (leap year first)
    //   S_YEAR  peel single years, at most three
    //   S_MONTH walk the cumulative-days table
    //   S_DAY   day of month, load the output register
    t_state      r_state, n_state;
    logic [31:0] r_sec, n_sec;
    t_word       r_rem, n_rem;
    t_word       r_div, n_div;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_cnt, n_cnt;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [5:0]  r_second, n_second;
    logic [2:0]  r_dow, n_dow;
    logic [7:0]  r_yidx, n_yidx;
    logic [3:0]  r_month, n_month;

    logic        r_out_valid;
    logic [11:0] r_year_o;
    logic [3:0]  r_month_o;
    logic [4:0]  r_day_o;
    logic [4:0]  r_hour_o;
    logic [5:0]  r_minute_o;
    logic [5:0]  r_second_o;
    logic [2:0]  r_dow_o;

    t_word       w_a, w_b, w_diff;
    logic        w_ge, w_gt;
    logic        w_leap;
    logic        w_out_free;
    logic        w_load;
    logic [3:0]  w_dow_sum;
    logic [2:0]  w_wk_rem;

    stc_subcmp u_alu (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge),
        .o_gt   (w_gt)
    );

    assign w_leap     = (r_yidx[1:0] == 2'b00);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_load     = (r_state == S_DAY) && w_out_free;
    assign o_stall    = (r_state != S_IDLE);

    // remainder of the last mod-7 step, then shift the weekday so day 0 is Friday
    assign w_wk_rem  = w_ge ? w_diff[2:0] : r_rem[2:0];
    assign w_dow_sum = {1'b0, w_wk_rem} + DOW_OFFSET;

    always_comb begin
        n_state  = r_state;
        n_sec    = r_sec;
        n_rem    = r_rem;
        n_div    = r_div;
        n_days   = r_days;
        n_cnt    = r_cnt;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_dow    = r_dow;
        n_yidx   = r_yidx;
        n_month  = r_month;
        w_a      = '0;
        w_b      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sec   = i_seconds;
                    n_rem   = '0;
                    n_days  = '0;
                    n_cnt   = 5'd31;
                    n_state = S_DAYS;
                end
            end
            S_DAYS: begin
                // shift in one dividend bit per cycle
                w_a    = {r_rem[ALU_W-2:0], r_sec[31]};
                w_b    = SEC_PER_DAY;
                n_rem  = w_ge ? w_diff : w_a;
                n_sec  = {r_sec[30:0], 1'b0};
                n_days = {r_days[14:0], w_ge};
                if (r_cnt == 5'd0) begin
                    n_div   = HOUR_DIV0;
                    n_cnt   = 5'd4;
                    n_state = S_HOUR;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_HOUR: begin
                w_a    = r_rem;
                w_b    = r_div;
                n_rem  = w_ge ? w_diff : r_rem;
                n_hour = {r_hour[3:0], w_ge};
                n_div  = {1'b0, r_div[ALU_W-1:1]};
                if (r_cnt == 5'd0) begin
                    n_div   = MIN_DIV0;
                    n_cnt   = 5'd5;
                    n_state = S_MIN;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_MIN: begin
                w_a      = r_rem;
                w_b      = r_div;
                n_rem    = w_ge ? w_diff : r_rem;
                n_minute = {r_minute[4:0], w_ge};
                n_div    = {1'b0, r_div[ALU_W-1:1]};
                if (r_cnt == 5'd0) begin
                    n_second = w_ge ? w_diff[5:0] : r_rem[5:0];
                    n_rem    = {2'b00, r_days};
                    n_div    = WEEK_DIV0;
                    n_cnt    = 5'd13;
                    n_state  = S_DOW;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_DOW: begin
                w_a   = r_rem;
                w_b   = r_div;
                n_rem = w_ge ? w_diff : r_rem;
                n_div = {1'b0, r_div[ALU_W-1:1]};
                if (r_cnt == 5'd0) begin
                    n_dow   = (w_dow_sum >= DAYS_IN_WEEK) ? 3'(w_dow_sum - DAYS_IN_WEEK)
                                                           : w_dow_sum[2:0];
                    n_yidx  = '0;
                    n_state = S_YEAR4;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_YEAR4: begin
                w_a = {2'b00, r_days};
                w_b = QUAD_DAYS;
                if (w_gt) begin
                    n_days = w_diff[15:0];
                    n_yidx = r_yidx + 8'd4;
                end else begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                w_a = {2'b00, r_days};
                w_b = w_leap ? LEAP_DAYS : COMMON_DAYS;
                if (w_gt) begin
                    n_days = w_diff[15:0];
                    n_yidx = r_yidx + 8'd1;
                end else begin
                    n_month = 4'd1;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                w_a = {2'b00, r_days};
                w_b = {9'd0, days_through(r_month, w_leap)};
                if (r_month != MONTH_DEC && w_gt) begin
                    n_month = r_month + 4'd1;
                end else begin
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                w_a = {2'b00, r_days};
                w_b = {9'd0, days_through(r_month - 4'd1, w_leap)};
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sec    <= n_sec;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_days   <= n_days;
        r_cnt    <= n_cnt;
        r_hour   <= n_hour;
        r_minute <= n_minute;
        r_second <= n_second;
        r_dow    <= n_dow;
        r_yidx   <= n_yidx;
        r_month  <= n_month;
    end

    // output register: holds the finished request while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            // day count zero never moved r_days, so it is still zero here
            if (r_days == 16'd0) begin
                r_year_o  <= YEAR_DAYZERO;
                r_month_o <= MONTH_DEC;
                r_day_o   <= DAY_LAST_DEC;
            end else begin
                r_year_o  <= YEAR_BASE + {4'b0000, r_yidx};
                r_month_o <= r_month;
                r_day_o   <= w_diff[4:0];
            end
            r_hour_o   <= r_hour;
            r_minute_o <= r_minute;
            r_second_o <= r_second;
            r_dow_o    <= r_dow;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_year        = r_year_o;
    assign o_month       = r_month_o;
    assign o_day         = r_day_o;
    assign o_hour        = r_hour_o;
    assign o_minute      = r_minute_o;
    assign o_second      = r_second_o;
    assign o_day_of_week = r_dow_o;

endmodule
